/* rtl/core/hstp_pkg.sv */
// Shared types, widths and the hue wheel table for the hue/shade/tint pattern.
// No dependencies; every module of the block but hstp_div_pipe imports this package.
package hstp_pkg;

   localparam int COORD_W     = 12;             // col and row
   localparam int DIM_W       = 13;             // frame sizes and divisors
   localparam int CHAN_W      = 8;              // one colour channel
   localparam int LANES       = 3;              // red, green, blue
   localparam int SEG_W       = 3;              // hue segment number
   localparam int SIX_Y_W     = COORD_W + 3;    // 6 * row
   localparam int NUM_W       = DIM_W + CHAN_W; // dividend of the 8 bit quotients
   localparam int HUE_SEGMENTS = 6;
   localparam int MAX_DIM_DEF  = 4096;

   localparam int WIDTH_RST  = 80;
   localparam int HEIGHT_RST = 24;
   localparam int WIDTH_MIN  = 2;
   localparam int HEIGHT_MIN = 1;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // lane 2 is red, lane 1 green, lane 0 blue
   localparam int LANE_RED   = 2;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE  = 0;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] half;
   } cfg_type;

   typedef struct packed {
      logic [LANES-1:0][CHAN_W-1:0] chan;
      logic [COORD_W-1:0]           col;
      logic                         out_of_range;
   } hue_word_type;

   // Channel mask of each peak on the wheel: {red, green, blue}, full or off.
   function automatic logic [LANES-1:0] peak_mask(input logic [SEG_W-1:0] seg);
      logic [LANES-1:0] mask;
      case (seg)
         3'd0:    mask = 3'b100;
         3'd1:    mask = 3'b110;
         3'd2:    mask = 3'b010;
         3'd3:    mask = 3'b011;
         3'd4:    mask = 3'b001;
         3'd5:    mask = 3'b101;
         default: mask = 3'b000;
      endcase
      return mask;
   endfunction

endpackage

/* rtl/core/hstp_csr.sv */
// Frame size registers with clamping applied on write.
// Depends on hstp_pkg.
module hstp_csr
   import hstp_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data,
   output cfg_type              cfg
);

   localparam int WIDTH_RST_C  = (WIDTH_RST > MAX_DIM) ? MAX_DIM : WIDTH_RST;
   localparam int HEIGHT_RST_C = (HEIGHT_RST > MAX_DIM) ? MAX_DIM : HEIGHT_RST;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;

   // saturate into [lo, MAX_DIM]; the upper bound never bites once MAX_DIM
   // exceeds the register width
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int lo);
      logic [DIM_W-1:0] r;
      if (32'(v) < lo)
         r = DIM_W'(lo);
      else if (32'(v) > MAX_DIM)
         r = DIM_W'(MAX_DIM);
      else
         r = v;
      return r;
   endfunction

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = clamp_dim(csr_data, WIDTH_MIN);
            CSR_FRAME_HEIGHT: height_in = clamp_dim(csr_data, HEIGHT_MIN);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(WIDTH_RST_C);
         height_ff <= DIM_W'(HEIGHT_RST_C);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;
   assign cfg.half   = width_ff >> 1;

endmodule

/* rtl/core/hstp_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one static divisor. Caller guarantees num_hi < divisor.
// Depends on nothing outside this file.
module hstp_div_pipe #(
   parameter int LANES = 1,
   parameter int DW    = 13,
   parameter int K     = 8,
   parameter int SW    = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      valid_i,
   input  logic [DW-1:0]             divisor_i,
   input  logic [LANES-1:0][DW-1:0]  num_hi_i,
   input  logic [LANES-1:0][K-1:0]   num_lo_i,
   input  logic [SW-1:0]             side_i,
   output logic                      valid_o,
   output logic [LANES-1:0][K-1:0]   quo_o,
   output logic [LANES-1:0][DW-1:0]  rem_o,
   output logic [SW-1:0]             side_o
);

   logic                     valid_ff [K];
   logic [LANES-1:0][DW-1:0] rem_ff   [K];
   logic [LANES-1:0][K-1:0]  lo_ff    [K];
   logic [LANES-1:0][K-1:0]  quo_ff   [K];
   logic [SW-1:0]            side_ff  [K];

   for (genvar s = 0; s < K; s++) begin : g_step
      logic                     src_valid;
      logic [LANES-1:0][DW-1:0] src_rem;
      logic [LANES-1:0][K-1:0]  src_lo;
      logic [LANES-1:0][K-1:0]  src_quo;
      logic [SW-1:0]            src_side;
      logic [LANES-1:0][DW-1:0] rem_in;
      logic [LANES-1:0][K-1:0]  lo_in;
      logic [LANES-1:0][K-1:0]  quo_in;

      if (s == 0) begin : g_first
         assign src_valid = valid_i;
         assign src_rem   = num_hi_i;
         assign src_lo    = num_lo_i;
         assign src_quo   = '0;
         assign src_side  = side_i;
      end else begin : g_next
         assign src_valid = valid_ff[s-1];
         assign src_rem   = rem_ff[s-1];
         assign src_lo    = lo_ff[s-1];
         assign src_quo   = quo_ff[s-1];
         assign src_side  = side_ff[s-1];
      end

      // bring down the next dividend bit, subtract where it fits
      always_comb begin
         logic [DW:0] trial;
         logic        qbit;
         for (int l = 0; l < LANES; l++) begin
            trial = {src_rem[l], src_lo[l][K-1]};
            qbit  = (trial >= {1'b0, divisor_i});
            if (qbit)
               rem_in[l] = DW'(trial - {1'b0, divisor_i});
            else
               rem_in[l] = trial[DW-1:0];
            lo_in[l]  = src_lo[l] << 1;
            quo_in[l] = (src_quo[l] << 1) | K'(qbit);
         end
      end

      always_ff @(posedge clock) begin
         if (reset)
            valid_ff[s] <= 1'b0;
         else
            valid_ff[s] <= src_valid;
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         lo_ff[s]   <= lo_in;
         quo_ff[s]  <= quo_in;
         side_ff[s] <= src_side;
      end
   end

   assign valid_o = valid_ff[K-1];
   assign quo_o   = quo_ff[K-1];
   assign rem_o   = rem_ff[K-1];
   assign side_o  = side_ff[K-1];

endmodule

/* rtl/core/hstp_hue.sv */
// Hue front end: frame check, hue segment and fraction from the row, then the
// three interpolated channel values. Depends on hstp_pkg and hstp_div_pipe.
module hstp_hue
   import hstp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         valid_i,
   input  req_type      req_i,
   input  cfg_type      cfg,
   output logic         valid_o,
   output hue_word_type hue_o
);

   localparam int SIDE_A_W = COORD_W + 1;
   localparam int SIDE_B_W = SEG_W + COORD_W + 1;

   // entry stage
   logic                 v0_ff;
   logic [COORD_W-1:0]   x0_ff;
   logic                 oor0_ff, oor0_in;
   logic [SIX_Y_W-1:0]   six_y_ff, six_y_in;

   always_comb begin
      oor0_in  = (DIM_W'(req_i.col) >= cfg.width) || (DIM_W'(req_i.row) >= cfg.height);
      six_y_in = (SIX_Y_W'(req_i.row) << 2) + (SIX_Y_W'(req_i.row) << 1);
   end

   always_ff @(posedge clock) begin
      if (reset)
         v0_ff <= 1'b0;
      else
         v0_ff <= valid_i;
   end

   always_ff @(posedge clock) begin
      x0_ff    <= req_i.col;
      oor0_ff  <= oor0_in;
      six_y_ff <= six_y_in;
   end

   // segment = 6y / H, fraction numerator f = 6y mod H
   logic                 va;
   logic [SEG_W-1:0]     seg_a;
   logic [DIM_W-1:0]     frac_a;
   logic [SIDE_A_W-1:0]  side_a;

   hstp_div_pipe #(
      .LANES (1),
      .DW    (DIM_W),
      .K     (SEG_W),
      .SW    (SIDE_A_W)
   ) u_seg_div (
      .clock     (clock),
      .reset     (reset),
      .valid_i   (v0_ff),
      .divisor_i (cfg.height),
      .num_hi_i  (DIM_W'(six_y_ff[SIX_Y_W-1:SEG_W])),
      .num_lo_i  (six_y_ff[SEG_W-1:0]),
      .side_i    ({x0_ff, oor0_ff}),
      .valid_o   (va),
      .quo_o     (seg_a),
      .rem_o     (frac_a),
      .side_o    (side_a)
   );

   // scale the fraction by 255 ahead of the second divide
   logic                 v1_ff;
   logic [NUM_W-1:0]     p255_ff, p255_in;
   logic [SIDE_B_W-1:0]  side1_ff;

   assign p255_in = (NUM_W'(frac_a) << CHAN_W) - NUM_W'(frac_a);

   always_ff @(posedge clock) begin
      if (reset)
         v1_ff <= 1'b0;
      else
         v1_ff <= va;
   end

   always_ff @(posedge clock) begin
      p255_ff  <= p255_in;
      side1_ff <= {seg_a, side_a};
   end

   logic                 vb;
   logic [CHAN_W-1:0]    q_b;
   logic [DIM_W-1:0]     r_b;
   logic [SIDE_B_W-1:0]  side_b;

   hstp_div_pipe #(
      .LANES (1),
      .DW    (DIM_W),
      .K     (CHAN_W),
      .SW    (SIDE_B_W)
   ) u_frac_div (
      .clock     (clock),
      .reset     (reset),
      .valid_i   (v1_ff),
      .divisor_i (cfg.height),
      .num_hi_i  (p255_ff[NUM_W-1:CHAN_W]),
      .num_lo_i  (p255_ff[CHAN_W-1:0]),
      .side_i    (side1_ff),
      .valid_o   (vb),
      .quo_o     (q_b),
      .rem_o     (r_b),
      .side_o    (side_b)
   );

   // pick each channel: full, off, rising ramp or falling ramp
   logic                 v2_ff;
   hue_word_type         hue_ff, hue_in;

   always_comb begin
      logic [SEG_W-1:0] seg;
      logic [SEG_W-1:0] nseg;
      logic [LANES-1:0] prv;
      logic [LANES-1:0] nxt;
      logic             rnz;
      seg  = side_b[SIDE_B_W-1 -: SEG_W];
      nseg = (seg == SEG_W'(HUE_SEGMENTS - 1)) ? '0 : seg + 1'b1;
      prv  = peak_mask(seg);
      nxt  = peak_mask(nseg);
      rnz  = (r_b != '0);
      hue_in.col          = side_b[COORD_W:1];
      hue_in.out_of_range = side_b[0];
      for (int k = 0; k < LANES; k++) begin
         case ({prv[k], nxt[k]})
            2'b11:   hue_in.chan[k] = '1;
            2'b01:   hue_in.chan[k] = q_b;
            2'b10:   hue_in.chan[k] = ~q_b - CHAN_W'(rnz);
            default: hue_in.chan[k] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         v2_ff <= 1'b0;
      else
         v2_ff <= vb;
   end

   always_ff @(posedge clock) begin
      hue_ff <= hue_in;
   end

   assign valid_o = v2_ff;
   assign hue_o   = hue_ff;

endmodule

/* rtl/core/hstp_ramp.sv */
// Column ramp: shade the hue from black over the left half, tint it toward
// white over the right half. Depends on hstp_pkg and hstp_div_pipe.
module hstp_ramp
   import hstp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         valid_i,
   input  hue_word_type hue_i,
   input  cfg_type      cfg,
   output logic         valid_o,
   output rsp_type      rsp_o
);

   localparam int SIDE_W = LANES * CHAN_W + 2;

   // left half: c*x/hw; right half: c + (255-c)*d/hw
   logic                         v0_ff;
   logic [DIM_W-1:0]             t_ff, t_in;
   logic [LANES-1:0][CHAN_W-1:0] m_ff, m_in;
   logic [LANES-1:0][CHAN_W-1:0] base0_ff, base0_in;
   logic                         white0_ff, white0_in;
   logic                         oor0_ff;

   always_comb begin
      logic             shade;
      logic [DIM_W-1:0] d;
      shade     = DIM_W'(hue_i.col) < cfg.half;
      d         = DIM_W'(hue_i.col) - cfg.half;
      white0_in = !shade && (d >= cfg.half);
      t_in      = shade ? DIM_W'(hue_i.col) : d;
      for (int k = 0; k < LANES; k++) begin
         m_in[k]     = shade ? hue_i.chan[k] : ~hue_i.chan[k];
         base0_in[k] = shade ? '0 : hue_i.chan[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         v0_ff <= 1'b0;
      else
         v0_ff <= valid_i;
   end

   always_ff @(posedge clock) begin
      t_ff      <= t_in;
      m_ff      <= m_in;
      base0_ff  <= base0_in;
      white0_ff <= white0_in;
      oor0_ff   <= hue_i.out_of_range;
   end

   // one 8 x 13 product per lane
   logic                        v1_ff;
   logic [LANES-1:0][NUM_W-1:0] prod_ff, prod_in;
   logic [SIDE_W-1:0]           side1_ff;
   logic [LANES-1:0][DIM_W-1:0] prod_hi;
   logic [LANES-1:0][CHAN_W-1:0] prod_lo;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         prod_in[k] = NUM_W'(m_ff[k]) * NUM_W'(t_ff);
         prod_hi[k] = prod_ff[k][NUM_W-1:CHAN_W];
         prod_lo[k] = prod_ff[k][CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         v1_ff <= 1'b0;
      else
         v1_ff <= v0_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      side1_ff <= {base0_ff, white0_ff, oor0_ff};
   end

   logic                         vq;
   logic [LANES-1:0][CHAN_W-1:0] quo;
   logic [SIDE_W-1:0]            side_q;

   hstp_div_pipe #(
      .LANES (LANES),
      .DW    (DIM_W),
      .K     (CHAN_W),
      .SW    (SIDE_W)
   ) u_ramp_div (
      .clock     (clock),
      .reset     (reset),
      .valid_i   (v1_ff),
      .divisor_i (cfg.half),
      .num_hi_i  (prod_hi),
      .num_lo_i  (prod_lo),
      .side_i    (side1_ff),
      .valid_o   (vq),
      .quo_o     (quo),
      .rem_o     (),
      .side_o    (side_q)
   );

   // add the base back, force white past the last full column, zero outside
   logic                         v2_ff;
   rsp_type                      rsp_ff, rsp_in;

   always_comb begin
      logic [LANES-1:0][CHAN_W-1:0] base;
      logic [LANES-1:0][CHAN_W-1:0] pix;
      logic                         white;
      logic                         oor;
      base  = side_q[SIDE_W-1:2];
      white = side_q[1];
      oor   = side_q[0];
      for (int k = 0; k < LANES; k++) begin
         if (oor)
            pix[k] = '0;
         else if (white)
            pix[k] = '1;
         else
            pix[k] = base[k] + quo[k];
      end
      rsp_in.red          = pix[LANE_RED];
      rsp_in.green        = pix[LANE_GREEN];
      rsp_in.blue         = pix[LANE_BLUE];
      rsp_in.out_of_range = oor;
   end

   always_ff @(posedge clock) begin
      if (reset)
         v2_ff <= 1'b0;
      else
         v2_ff <= vq;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign valid_o = v2_ff;
   assign rsp_o   = rsp_ff;

endmodule

/* rtl/core/hue_shade_tint_pattern.sv */
// Top level of the hue wheel test pattern generator.
// Depends on hstp_pkg, hstp_csr, hstp_hue and hstp_ramp.
//
//   channel   ports                                  word
//   -------   ------------------------------------   --------------------------
//   request   start, busy, req_data                  req_type: col, row
//   response  rsp_valid, rsp_data                    rsp_type: red, green, blue,
//                                                    out_of_range
//   control   csr_valid, csr_ready, csr_index,       frame_width, frame_height
//             csr_data
//
// One pixel per clock; each result passes through the pipelined dividers:
// 3 stages for the hue segment, 8 for the hue fraction and 8 for the column
// ramp, plus six staging registers.
// Synchronous reset empties the pipeline and restores an 80 x 24 frame.
// The response side takes a word every cycle, so busy stays low and the
// pipeline always advances; csr_ready is always high.
module hue_shade_tint_pattern
   import hstp_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   cfg_type      cfg;
   logic         accept;
   logic         hue_valid;
   hue_word_type hue_word;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   hstp_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hstp_hue u_hue (
      .clock   (clock),
      .reset   (reset),
      .valid_i (accept),
      .req_i   (req_data),
      .cfg     (cfg),
      .valid_o (hue_valid),
      .hue_o   (hue_word)
   );

   hstp_ramp u_ramp (
      .clock   (clock),
      .reset   (reset),
      .valid_i (hue_valid),
      .hue_i   (hue_word),
      .cfg     (cfg),
      .valid_o (rsp_valid),
      .rsp_o   (rsp_data)
   );

endmodule
